/* rtl/rth_pkg.sv */
// Shared types and constants for the 8-bit RGB to HSV converter.
// Used by every module of the converter; depends on nothing else.
`default_nettype none

package rth_pkg;

  localparam int unsigned ChanWidth = 8;
  localparam int unsigned QuotBits  = 8;
  localparam int unsigned NumCells  = QuotBits;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  // Partial results of both divisions as they pass along the row of cells.
  typedef struct packed {
    logic [ChanWidth-1:0] rem_s;
    logic [ChanWidth-1:0] lo_s;
    logic [ChanWidth-1:0] div_s;
    logic [ChanWidth-1:0] rem_h;
    logic [ChanWidth-1:0] lo_h;
    logic [ChanWidth-1:0] div_h;
    sector_t              sector;
    logic                 neg;
    logic                 gray;
  } work_t;

endpackage

`default_nettype wire

/* rtl/rth_front.sv */
// Input stage: channel maximum and minimum, hue sector and both dividends.
// Depends on rth_pkg.
`default_nettype none

module rth_front import rth_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic [ChanWidth-1:0] red,
  input  wire logic [ChanWidth-1:0] green,
  input  wire logic [ChanWidth-1:0] blue,
  output logic                      out_valid,
  output work_t                     out_work
);

  logic [ChanWidth-1:0] vmax;
  logic [ChanWidth-1:0] vmin;
  logic [ChanWidth-1:0] span;
  logic [ChanWidth-1:0] pos;
  logic [ChanWidth-1:0] negv;
  logic [ChanWidth-1:0] mag;
  logic                 neg;
  sector_t              sector;
  logic [15:0]          sat_num;
  logic [15:0]          hue_num;
  work_t                work_next;

  always_comb begin
    vmax = (red > green) ? red : green;
    if (blue > vmax) begin
      vmax = blue;
    end
    vmin = (red < green) ? red : green;
    if (blue < vmin) begin
      vmin = blue;
    end
    span = vmax - vmin;

    if (blue == vmax) begin
      sector = SEC_BLUE;
      pos    = red;
      negv   = green;
    end else if (green == vmax) begin
      sector = SEC_GREEN;
      pos    = blue;
      negv   = red;
    end else begin
      sector = SEC_RED;
      pos    = green;
      negv   = blue;
    end
    neg = pos < negv;
    mag = neg ? (negv - pos) : (pos - negv);

    sat_num = {span, 8'd0} - {8'd0, span};
    hue_num = {2'd0, mag, 6'd0} - {6'd0, mag, 2'd0};

    work_next.rem_s  = sat_num[15:8];
    work_next.lo_s   = sat_num[7:0];
    work_next.div_s  = vmax;
    work_next.rem_h  = hue_num[15:8];
    work_next.lo_h   = hue_num[7:0];
    work_next.div_h  = span;
    work_next.sector = sector;
    work_next.neg    = neg;
    work_next.gray   = (span == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_work <= work_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/rth_div_cell.sv */
// One restoring division cell: yields one quotient bit of both the saturation
// and the hue division per transfer through it. Depends on rth_pkg.
`default_nettype none

module rth_div_cell import rth_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire logic  in_valid,
  input  wire work_t in_work,
  output logic       out_valid,
  output work_t      out_work
);

  logic [ChanWidth:0]   trial_s;
  logic [ChanWidth:0]   trial_h;
  logic [ChanWidth:0]   diff_s;
  logic [ChanWidth:0]   diff_h;
  logic                 ge_s;
  logic                 ge_h;
  work_t                work_next;

  always_comb begin
    trial_s = {in_work.rem_s, in_work.lo_s[ChanWidth-1]};
    trial_h = {in_work.rem_h, in_work.lo_h[ChanWidth-1]};
    diff_s  = trial_s - {1'b0, in_work.div_s};
    diff_h  = trial_h - {1'b0, in_work.div_h};
    ge_s    = trial_s >= {1'b0, in_work.div_s};
    ge_h    = trial_h >= {1'b0, in_work.div_h};

    work_next       = in_work;
    work_next.rem_s = ge_s ? diff_s[ChanWidth-1:0] : trial_s[ChanWidth-1:0];
    work_next.rem_h = ge_h ? diff_h[ChanWidth-1:0] : trial_h[ChanWidth-1:0];
    work_next.lo_s  = {in_work.lo_s[ChanWidth-2:0], ge_s};
    work_next.lo_h  = {in_work.lo_h[ChanWidth-2:0], ge_h};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_work <= work_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/rth_back.sv */
// Output stage: adds the sector offset to the hue quotient, wraps and halves
// it, and holds the finished pixel. Depends on rth_pkg.
`default_nettype none

module rth_back import rth_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire work_t                in_work,
  output logic                      out_valid,
  output logic [ChanWidth-1:0]      hue,
  output logic [ChanWidth-1:0]      sat,
  output logic [ChanWidth-1:0]      val
);

  logic [8:0] q;
  logic [8:0] deg;
  logic [7:0] hue_next;
  logic [7:0] sat_next;

  always_comb begin
    q = {1'b0, in_work.lo_h};
    unique case (in_work.sector)
      SEC_BLUE:  deg = in_work.neg ? (9'd240 - q) : (9'd240 + q);
      SEC_GREEN: deg = in_work.neg ? (9'd120 - q) : (9'd120 + q);
      SEC_RED:   deg = (in_work.neg && (q != '0)) ? (9'd360 - q) : q;
      default:   deg = '0;
    endcase
    hue_next = in_work.gray ? 8'd0 : deg[8:1];
    sat_next = in_work.gray ? 8'd0 : in_work.lo_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue <= hue_next;
      sat <= sat_next;
      val <= in_work.div_s;
    end
  end

endmodule

`default_nettype wire

/* rtl/rgb_to_hsv_8bit.sv */
// Top level of the 8-bit RGB to HSV converter with hue in half degrees.
// Instantiates rth_front, a row of rth_div_cell and rth_back; uses rth_pkg.
`default_nettype none

// The converter takes one pixel per clock while the pipeline advances, and its
// HSV result passes through ten register stages on the way to the outputs: one
// input stage, a row of eight division cells that each settle one quotient bit
// of the saturation and hue divisions, and one output stage. The whole pipeline
// advances together whenever its last stage is empty or its result is being
// taken, so a full pipeline with ready held high sustains one pixel per cycle.

module rgb_to_hsv_8bit import rth_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [ChanWidth-1:0] red_in,
  input  wire logic [ChanWidth-1:0] green_in,
  input  wire logic [ChanWidth-1:0] blue_in,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [ChanWidth-1:0]      hue_out,
  output logic [ChanWidth-1:0]      sat_out,
  output logic [ChanWidth-1:0]      val_out
);

  logic  en;
  logic  cell_valid [NumCells+1];
  work_t cell_work  [NumCells+1];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  rth_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .red       (red_in),
    .green     (green_in),
    .blue      (blue_in),
    .out_valid (cell_valid[0]),
    .out_work  (cell_work[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    rth_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (cell_valid[i]),
      .in_work   (cell_work[i]),
      .out_valid (cell_valid[i+1]),
      .out_work  (cell_work[i+1])
    );
  end

  rth_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cell_valid[NumCells]),
    .in_work   (cell_work[NumCells]),
    .out_valid (out_valid),
    .hue       (hue_out),
    .sat       (sat_out),
    .val       (val_out)
  );

endmodule

`default_nettype wire

/* bench/rgb_to_hsv_8bit_tb.sv */
// Self-checking testbench for rgb_to_hsv_8bit: directed pixels, then random ones.
// Holds its own HSV predictor; needs rth_pkg and the converter RTL.

module rgb_to_hsv_8bit_tb;
  import rth_pkg::*;

  localparam int RandomPixels = 1430;
  localparam int CalmPixels   = 200;
  localparam int DrainCycles  = 20;
  localparam int CycleLimit   = 400000;

  typedef struct packed {
    logic [ChanWidth-1:0] hue;
    logic [ChanWidth-1:0] sat;
    logic [ChanWidth-1:0] val;
  } hsv_t;

  typedef struct packed {
    logic [ChanWidth-1:0] r;
    logic [ChanWidth-1:0] g;
    logic [ChanWidth-1:0] b;
    bit                   known;
    hsv_t                 want;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic [ChanWidth-1:0] red_in = '0;
  logic [ChanWidth-1:0] green_in = '0;
  logic [ChanWidth-1:0] blue_in = '0;
  logic in_ready;
  logic out_valid;
  logic [ChanWidth-1:0] hue_out;
  logic [ChanWidth-1:0] sat_out;
  logic [ChanWidth-1:0] val_out;

  hsv_t pending_hsv[$];
  int   mismatches = 0;
  int   cycle_count = 0;
  bit   calm = 1'b0;
  bit   hold_req = 1'b0;
  bit   hold_done = 1'b0;

  // Rows marked known carry their expected HSV; the rest go through the predictor.
  pixel_row_t directed_rows [0:22] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{8'd255, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{8'd128, 8'd128, 8'd128, 1'b1, '{8'd0,   8'd0,   8'd128}},
    '{8'd1,   8'd1,   8'd1,   1'b1, '{8'd0,   8'd0,   8'd1}},
    '{8'd255, 8'd0,   8'd0,   1'b1, '{8'd0,   8'd255, 8'd255}},
    '{8'd0,   8'd255, 8'd0,   1'b1, '{8'd60,  8'd255, 8'd255}},
    '{8'd0,   8'd0,   8'd255, 1'b1, '{8'd120, 8'd255, 8'd255}},
    '{8'd1,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd255, 8'd1}},
    '{8'd255, 8'd255, 8'd0,   1'b1, '{8'd30,  8'd255, 8'd255}},
    '{8'd0,   8'd255, 8'd255, 1'b1, '{8'd90,  8'd255, 8'd255}},
    '{8'd255, 8'd0,   8'd255, 1'b1, '{8'd150, 8'd255, 8'd255}},
    '{8'd255, 8'd0,   8'd5,   1'b0, '0},
    '{8'd255, 8'd0,   8'd1,   1'b0, '0},
    '{8'd255, 8'd5,   8'd0,   1'b0, '0},
    '{8'd0,   8'd5,   8'd255, 1'b0, '0},
    '{8'd5,   8'd0,   8'd255, 1'b0, '0},
    '{8'd254, 8'd255, 8'd254, 1'b0, '0},
    '{8'd255, 8'd254, 8'd255, 1'b0, '0},
    '{8'd128, 8'd127, 8'd127, 1'b0, '0},
    '{8'd1,   8'd2,   8'd3,   1'b0, '0},
    '{8'd85,  8'd170, 8'd255, 1'b0, '0},
    '{8'd170, 8'd85,  8'd0,   1'b0, '0},
    '{8'd255, 8'd128, 8'd128, 1'b0, '0}
  };

  rgb_to_hsv_8bit uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .red_in   (red_in),
    .green_in (green_in),
    .blue_in  (blue_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .hue_out  (hue_out),
    .sat_out  (sat_out),
    .val_out  (val_out)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic hsv_t hsv_from_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    hsv_t px;
    int ri, gi, bi, hi, lo, span, diff, base, deg;
    ri = r;
    gi = g;
    bi = b;
    hi = (ri > gi) ? ri : gi;
    hi = (hi > bi) ? hi : bi;
    lo = (ri < gi) ? ri : gi;
    lo = (lo < bi) ? lo : bi;
    span = hi - lo;
    deg = 0;
    px.val = 8'(hi);
    px.sat = (hi == 0) ? 8'd0 : 8'((span * 255) / hi);
    if (span != 0) begin
      if (bi == hi) begin
        diff = ri - gi;
        base = 240;
      end else if (gi == hi) begin
        diff = bi - ri;
        base = 120;
      end else begin
        diff = gi - bi;
        base = 0;
      end
      deg = (diff * 60) / span + base;
      if (deg < 0) deg += 360;
    end
    px.hue = 8'(deg / 2);
    return px;
  endfunction

  task automatic pick_pixel(output logic [7:0] r, output logic [7:0] g, output logic [7:0] b);
    int mode, hi, odd, spot;
    mode = $urandom_range(0, 99);
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    if (mode < 50) begin
      return;
    end else if (mode < 66) begin
      hi = $urandom_range(0, 255);
      odd = $urandom_range(0, hi);
      spot = $urandom_range(0, 2);
      r = (spot == 0) ? 8'(odd) : 8'(hi);
      g = (spot == 1) ? 8'(odd) : 8'(hi);
      b = (spot == 2) ? 8'(odd) : 8'(hi);
    end else if (mode < 72) begin
      r = 8'($urandom);
      g = r;
      b = r;
    end else if (mode < 82) begin
      r = 8'($urandom_range(0, 3));
      g = 8'($urandom_range(0, 3));
      b = 8'($urandom_range(0, 3));
    end else if (mode < 90) begin
      r = 8'($urandom_range(252, 255));
      g = 8'($urandom_range(252, 255));
      b = 8'($urandom_range(252, 255));
    end else begin
      spot = $urandom_range(0, 2);
      if (spot == 0) r = 8'd255;
      else if (spot == 1) g = 8'd255;
      else b = 8'd255;
    end
  endtask

  // Holds the pixel until the transfer completes, then records what it should become.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input hsv_t want);
    red_in   <= r;
    green_in <= g;
    blue_in  <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_hsv.push_back(want);
  endtask

  task automatic sender_gap(input int idx);
    if (!calm && (idx / 100) % 3 != 2 && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  initial begin
    logic [7:0] r, g, b;
    hsv_t want;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      want = directed_rows[i].known ? directed_rows[i].want :
             hsv_from_rgb(directed_rows[i].r, directed_rows[i].g, directed_rows[i].b);
      send_pixel(directed_rows[i].r, directed_rows[i].g, directed_rows[i].b, want);
      sender_gap(i);
    end
    for (int i = 0; i < RandomPixels; i++) begin
      if (i == 400) hold_req = 1'b1;
      if (i == 800) begin
        in_valid <= 1'b0;
        while (pending_hsv.size() != 0) @(posedge clk);
      end
      if (i == RandomPixels - CalmPixels) calm = 1'b1;
      pick_pixel(r, g, b);
      send_pixel(r, g, b, hsv_from_rgb(r, g, b));
      sender_gap(i);
    end
    in_valid <= 1'b0;
    while (pending_hsv.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off to back the pipeline up, none at the end.
  initial begin
    int stretch;
    stretch = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stretch++;
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (80) @(posedge clk);
        hold_done = 1'b1;
      end else if (!calm && (stretch / 150) % 3 != 1 && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    hsv_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_hsv.size() == 0) begin
        $error("unexpected result transfer: hue %0d sat %0d val %0d",
               hue_out, sat_out, val_out);
        mismatches++;
      end else begin
        want = pending_hsv.pop_front();
        if (hue_out !== want.hue) begin
          $error("hue_out: expected %0d, actual %0d", want.hue, hue_out);
          mismatches++;
        end
        if (sat_out !== want.sat) begin
          $error("sat_out: expected %0d, actual %0d", want.sat, sat_out);
          mismatches++;
        end
        if (val_out !== want.val) begin
          $error("val_out: expected %0d, actual %0d", want.val, val_out);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule

/* rgb_to_hsv_8bit.f */
rtl/rth_pkg.sv
rtl/rth_front.sv
rtl/rth_div_cell.sv
rtl/rth_back.sv
rtl/rgb_to_hsv_8bit.sv
bench/rgb_to_hsv_8bit_tb.sv
